// ----- rtl/tilt_compensated_compass_heading_defines.svh -----
// Assertion macros shared by the compass heading RTL.
// Depends on a clock named clock and a reset named reset in the including module.
`ifndef TILT_COMPENSATED_COMPASS_HEADING_DEFINES_SVH
`define TILT_COMPENSATED_COMPASS_HEADING_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TCCH_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TCCH_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/tcch_pkg.sv -----
// Types, constants and the arctangent table of the compass heading pipeline.
// Depends on nothing; used by the top level.
package tcch_pkg;

   localparam int unsigned FLAT_LIMIT   = 268;
   localparam int unsigned HEADING_WRAP = 36000;

   typedef enum logic [2:0] {
      CSR_BIAS_X  = 3'd0,
      CSR_BIAS_Y  = 3'd1,
      CSR_BIAS_Z  = 3'd2,
      CSR_SCALE_X = 3'd3,
      CSR_SCALE_Y = 3'd4,
      CSR_SCALE_Z = 3'd5
   } csr_idx_type;

   // Word carried through the square root stages.
   typedef struct packed {
      logic signed [40:0] a;
      logic signed [63:0] hy;
      logic signed [23:0] mx;
      logic signed [23:0] mz;
      logic               ay_pos;
      logic               rxz0;
      logic               flat;
      logic        [48:0] n;
      logic        [48:0] r;
   } isq_type;

   // Word carried through the normalizing shifter.
   typedef struct packed {
      logic [63:0] ux;
      logic [63:0] uy;
      logic        xneg;
      logic        yneg;
      logic        zero;
      logic        flat;
   } norm_type;

   // Word carried through the CORDIC stages.
   typedef struct packed {
      logic signed [32:0] cx;
      logic signed [32:0] cy;
      logic signed [33:0] z;
      logic               xneg;
      logic               yneg;
      logic               zero;
      logic               flat;
   } cor_type;

   // Arctangent of 2^-i in 2^32-per-turn units.
   function automatic logic [31:0] atan_tab(input int unsigned i);
      logic [31:0] v;
      unique case (i)
         0:  v = 32'd536870912;
         1:  v = 32'd316933406;
         2:  v = 32'd167458907;
         3:  v = 32'd85004756;
         4:  v = 32'd42667331;
         5:  v = 32'd21354465;
         6:  v = 32'd10679838;
         7:  v = 32'd5340245;
         8:  v = 32'd2670163;
         9:  v = 32'd1335087;
         10: v = 32'd667544;
         11: v = 32'd333772;
         12: v = 32'd166886;
         13: v = 32'd83443;
         14: v = 32'd41722;
         15: v = 32'd20861;
         16: v = 32'd10430;
         17: v = 32'd5215;
         18: v = 32'd2608;
         19: v = 32'd1304;
         20: v = 32'd652;
         21: v = 32'd326;
         22: v = 32'd163;
         23: v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   // Soft-iron gain, rounded half up: (d * scale + 2^13) >> 14.
   function automatic logic signed [23:0] calib(input logic signed [20:0] d,
                                               input logic [15:0] scale);
      logic signed [37:0] p;
      p = 38'(d) * 38'($signed({1'b0, scale}));
      p = p + 38'sd8192;
      return p[37:14];
   endfunction

endpackage

// ----- rtl/tcch_channels.sv -----
// Valid/ready channel interfaces for the compass heading block.
// Depends on nothing.
interface tcch_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic signed [15:0] mag_x;
   logic signed [15:0] mag_y;
   logic signed [15:0] mag_z;
   modport source(output valid, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z,
                  input ready);
   modport sink(input valid, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z,
                output ready);
endinterface

interface tcch_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] heading;
   logic        free_fall;
   modport source(output valid, heading, free_fall, input ready);
   modport sink(input valid, heading, free_fall, output ready);
endinterface

// ----- rtl/tilt_compensated_compass_heading.sv -----
// Top level of the tilt-compensated compass heading pipeline.
// Depends on tcch_pkg, tcch_channels.sv and tilt_compensated_compass_heading_defines.svh.
//
// Usage. Each word on req_if holds one accelerometer and one magnetometer
// sample; each word on rsp_if holds the heading in hundredths of a degree
// (0 to 35999, clockwise) and a flag that is set when gravity was too weak
// and the unit was assumed flat. Calibration lives in six APB registers
// (hard-iron biases, then soft-iron gains) at byte addresses 0 to 20.
// Throughput is one word per cycle while the receiver holds ready. The
// pipeline is built from the 24 stages of the bit-per-stage square
// root, the CORDIC stages and the multiplier stages around them.
// The whole pipeline advances on one enable. When the receiver deasserts
// ready while the output register is full, every stage holds and req_if
// ready drops; nothing is lost or repeated. Reset clears all valid bits
// and restores the register defaults. Registers should be written only
// while the pipeline is empty.
`include "tilt_compensated_compass_heading_defines.svh"

module tilt_compensated_compass_heading #(
   parameter int unsigned CORDIC_STAGES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   tcch_req_if.sink             req_if,
   tcch_rsp_if.source           rsp_if,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [4:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   // Stage count: 4 front, 25 square root, 3 multiply/select/abs,
   // 6 normalize, CORDIC, then angle, product and output.
   localparam int unsigned NSQ = 24;
   localparam int unsigned NST = 41 + CORDIC_STAGES;

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   logic signed [19:0] bias_x_ff, bias_y_ff, bias_z_ff;
   logic        [15:0] scale_x_ff, scale_y_ff, scale_z_ff;
   logic               csr_wr;
   tcch_pkg::csr_idx_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = tcch_pkg::csr_idx_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_x_ff  <= 20'sd443;
         bias_y_ff  <= 20'sd75;
         bias_z_ff  <= 20'sd4628;
         scale_x_ff <= 16'd15665;
         scale_y_ff <= 16'd14033;
         scale_z_ff <= 16'd20832;
      end else if (csr_wr) begin
         unique case (csr_idx)
            tcch_pkg::CSR_BIAS_X:  bias_x_ff  <= csr_pwdata[19:0];
            tcch_pkg::CSR_BIAS_Y:  bias_y_ff  <= csr_pwdata[19:0];
            tcch_pkg::CSR_BIAS_Z:  bias_z_ff  <= csr_pwdata[19:0];
            tcch_pkg::CSR_SCALE_X: scale_x_ff <= csr_pwdata[15:0];
            tcch_pkg::CSR_SCALE_Y: scale_y_ff <= csr_pwdata[15:0];
            tcch_pkg::CSR_SCALE_Z: scale_z_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         tcch_pkg::CSR_BIAS_X:  csr_prdata = 32'(bias_x_ff);
         tcch_pkg::CSR_BIAS_Y:  csr_prdata = 32'(bias_y_ff);
         tcch_pkg::CSR_BIAS_Z:  csr_prdata = 32'(bias_z_ff);
         tcch_pkg::CSR_SCALE_X: csr_prdata = {16'd0, scale_x_ff};
         tcch_pkg::CSR_SCALE_Y: csr_prdata = {16'd0, scale_y_ff};
         tcch_pkg::CSR_SCALE_Z: csr_prdata = {16'd0, scale_z_ff};
         default:               csr_prdata = 32'd0;
      endcase
   end

   // ------------------------------------------------------------------
   // Pipeline control. One valid bit per stage, shifted on a common
   // enable that drops only when the output register is full and stalled.
   // ------------------------------------------------------------------
   logic           en;
   logic [NST-1:0] vld_ff, vld_in;

   assign en           = !vld_ff[NST-1] || rsp_if.ready;
   assign req_if.ready = en;
   assign vld_in       = {vld_ff[NST-2:0], req_if.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: scale raw field to 0.01 uT, remove hard iron; square gravity.
   // ------------------------------------------------------------------
   logic signed [20:0] mx21, my21, mz21;
   logic signed [20:0] dx_ff, dy_ff, dz_ff, dx_in, dy_in, dz_in;
   logic signed [15:0] ax1_ff, ay1_ff, az1_ff;
   logic        [30:0] ax2_ff, ay2_ff, az2_ff, ax2_in, ay2_in, az2_in;

   always_comb begin
      mx21   = 21'(req_if.mag_x);
      my21   = 21'(req_if.mag_y);
      mz21   = 21'(req_if.mag_z);
      dx_in  = (mx21 <<< 4) - mx21 - 21'(bias_x_ff);
      dy_in  = (my21 <<< 4) - my21 - 21'(bias_y_ff);
      dz_in  = (mz21 <<< 4) - mz21 - 21'(bias_z_ff);
      ax2_in = 31'(32'(req_if.accel_x) * 32'(req_if.accel_x));
      ay2_in = 31'(32'(req_if.accel_y) * 32'(req_if.accel_y));
      az2_in = 31'(32'(req_if.accel_z) * 32'(req_if.accel_z));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         dz_ff  <= dz_in;
         ax2_ff <= ax2_in;
         ay2_ff <= ay2_in;
         az2_ff <= az2_in;
         ax1_ff <= req_if.accel_x;
         ay1_ff <= req_if.accel_y;
         az1_ff <= req_if.accel_z;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: soft-iron gain and axis remap; squared gravity magnitude and the
   // free-fall test, which substitutes a flat gravity vector.
   // ------------------------------------------------------------------
   logic signed [23:0] mx2_ff, my2_ff, mz2_ff, mx2_in, my2_in, mz2_in;
   logic signed [15:0] ax2v_ff, ay2v_ff, az2v_ff, ax2v_in, ay2v_in, az2v_in;
   logic        [31:0] s2_ff, s2_in, rxz2_ff, rxz2_in, s_sum;
   logic               flat2_ff, flat2_in;

   always_comb begin
      mx2_in  = tcch_pkg::calib(dy_ff, scale_y_ff);
      my2_in  = tcch_pkg::calib(dx_ff, scale_x_ff);
      mz2_in  = -tcch_pkg::calib(dz_ff, scale_z_ff);
      s_sum   = 32'(ax2_ff) + 32'(ay2_ff) + 32'(az2_ff);
      flat2_in = s_sum <= 32'(tcch_pkg::FLAT_LIMIT);
      if (flat2_in) begin
         ax2v_in = 16'sd0;
         ay2v_in = 16'sd0;
         az2v_in = 16'sd1;
         s2_in   = 32'd1;
         rxz2_in = 32'd1;
      end else begin
         ax2v_in = ax1_ff;
         ay2v_in = ay1_ff;
         az2v_in = az1_ff;
         s2_in   = s_sum;
         rxz2_in = 32'(ax2_ff) + 32'(az2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mx2_ff   <= mx2_in;
         my2_ff   <= my2_in;
         mz2_ff   <= mz2_in;
         ax2v_ff  <= ax2v_in;
         ay2v_ff  <= ay2v_in;
         az2v_ff  <= az2v_in;
         s2_ff    <= s2_in;
         rxz2_ff  <= rxz2_in;
         flat2_ff <= flat2_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: the products of the horizontal projection.
   // ------------------------------------------------------------------
   logic signed [39:0] p1_ff, p2_ff, p3_ff, p4_ff;
   logic signed [56:0] p5_ff;
   logic signed [23:0] mx3_ff, mz3_ff;
   logic signed [15:0] ay3_ff;
   logic        [31:0] s3_ff;
   logic               rxz0_3_ff, flat3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff     <= 40'(mx2_ff) * 40'(az2v_ff);
         p2_ff     <= 40'(mz2_ff) * 40'(ax2v_ff);
         p3_ff     <= 40'(mx2_ff) * 40'(ax2v_ff);
         p4_ff     <= 40'(mz2_ff) * 40'(az2v_ff);
         p5_ff     <= 57'(my2_ff) * 57'($signed({1'b0, rxz2_ff}));
         mx3_ff    <= mx2_ff;
         mz3_ff    <= mz2_ff;
         ay3_ff    <= ay2v_ff;
         s3_ff     <= s2_ff;
         rxz0_3_ff <= rxz2_ff == 32'd0;
         flat3_ff  <= flat2_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: sums of the products.
   // ------------------------------------------------------------------
   logic signed [40:0] a4_ff, b4_ff;
   logic signed [56:0] p5_4_ff;
   logic signed [23:0] mx4_ff, mz4_ff;
   logic signed [15:0] ay4_ff;
   logic        [31:0] s4_ff;
   logic               rxz0_4_ff, flat4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         a4_ff     <= 41'(p1_ff) + 41'(p2_ff);
         b4_ff     <= 41'(p3_ff) - 41'(p4_ff);
         p5_4_ff   <= p5_ff;
         mx4_ff    <= mx3_ff;
         mz4_ff    <= mz3_ff;
         ay4_ff    <= ay3_ff;
         s4_ff     <= s3_ff;
         rxz0_4_ff <= rxz0_3_ff;
         flat4_ff  <= flat3_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: the Y component, and the square root seed of |a|^2 * 2^16.
   // ------------------------------------------------------------------
   tcch_pkg::isq_type isq_ff [0:NSQ];
   tcch_pkg::isq_type isq_in [1:NSQ];
   tcch_pkg::isq_type isq0_in;
   logic signed [56:0] ayb;

   always_comb begin
      ayb            = 57'(ay4_ff) * 57'(b4_ff);
      isq0_in.a      = a4_ff;
      isq0_in.hy     = (64'(p5_4_ff) - 64'(ayb)) <<< 8;
      isq0_in.mx     = mx4_ff;
      isq0_in.mz     = mz4_ff;
      isq0_in.ay_pos = ay4_ff > 16'sd0;
      isq0_in.rxz0   = rxz0_4_ff;
      isq0_in.flat   = flat4_ff;
      isq0_in.n      = {1'b0, s4_ff, 16'd0};
      isq0_in.r      = 49'd0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         isq_ff[0] <= isq0_in;
      end
   end

   // Square root stages: one result bit per stage, restoring form.
   for (genvar k = 0; k < NSQ; k++) begin : g_isq
      localparam logic [48:0] SQ_BIT = 49'd1 << (46 - 2 * k);
      logic [48:0] sq_t;
      always_comb begin
         isq_in[k+1] = isq_ff[k];
         sq_t        = isq_ff[k].r + SQ_BIT;
         if (isq_ff[k].n >= sq_t) begin
            isq_in[k+1].n = isq_ff[k].n - sq_t;
            isq_in[k+1].r = (isq_ff[k].r >> 1) + SQ_BIT;
         end else begin
            isq_in[k+1].r = isq_ff[k].r >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            isq_ff[k+1] <= isq_in[k+1];
         end
      end
   end

   // ------------------------------------------------------------------
   // X component: a * an, split into two partial products.
   // ------------------------------------------------------------------
   logic        [24:0] an;
   logic signed [53:0] pl_ff;
   logic signed [54:0] ph_ff;
   logic signed [63:0] hyA_ff;
   logic signed [23:0] mxA_ff, mzA_ff;
   logic               ayposA_ff, rxz0A_ff, flatA_ff;

   assign an = isq_ff[NSQ].r[24:0];

   always_ff @(posedge clock) begin
      if (en) begin
         pl_ff     <= 54'(isq_ff[NSQ].a) * 54'($signed({1'b0, an[11:0]}));
         ph_ff     <= 55'(isq_ff[NSQ].a) * 55'($signed({1'b0, an[24:12]}));
         hyA_ff    <= isq_ff[NSQ].hy;
         mxA_ff    <= isq_ff[NSQ].mx;
         mzA_ff    <= isq_ff[NSQ].mz;
         ayposA_ff <= isq_ff[NSQ].ay_pos;
         rxz0A_ff  <= isq_ff[NSQ].rxz0;
         flatA_ff  <= isq_ff[NSQ].flat;
      end
   end

   // Combine partial products; gravity along Y alone takes the field directly.
   logic signed [63:0] x_ff, y_ff, x_in, y_in;
   logic               flatB_ff;

   always_comb begin
      if (rxz0A_ff) begin
         x_in = 64'(mxA_ff);
         y_in = ayposA_ff ? 64'(mzA_ff) : -64'(mzA_ff);
      end else begin
         x_in = (64'(ph_ff) <<< 12) + 64'(pl_ff);
         y_in = hyA_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         flatB_ff <= flatA_ff;
      end
   end

   // ------------------------------------------------------------------
   // Magnitudes and quadrant, then a six-step left normalization that
   // puts the leading one of |X| | |Y| at bit 63.
   // ------------------------------------------------------------------
   tcch_pkg::norm_type norm_ff [0:6];
   tcch_pkg::norm_type norm_in [0:6];

   always_comb begin
      norm_in[0].ux   = x_ff[63] ? 64'(-x_ff) : 64'(x_ff);
      norm_in[0].uy   = y_ff[63] ? 64'(-y_ff) : 64'(y_ff);
      norm_in[0].xneg = x_ff[63];
      norm_in[0].yneg = y_ff[63];
      norm_in[0].zero = (x_ff == 64'sd0) && (y_ff == 64'sd0);
      norm_in[0].flat = flatB_ff;
   end

   for (genvar j = 1; j <= 6; j++) begin : g_norm
      localparam int unsigned SH = 64 >> j;
      localparam logic [63:0] TOP = ~({64{1'b1}} >> SH);
      always_comb begin
         norm_in[j] = norm_ff[j-1];
         if (((norm_ff[j-1].ux | norm_ff[j-1].uy) & TOP) == 64'd0) begin
            norm_in[j].ux = norm_ff[j-1].ux << SH;
            norm_in[j].uy = norm_ff[j-1].uy << SH;
         end
      end
   end

   for (genvar j = 0; j <= 6; j++) begin : g_norm_reg
      always_ff @(posedge clock) begin
         if (en) begin
            norm_ff[j] <= norm_in[j];
         end
      end
   end

   // ------------------------------------------------------------------
   // Vectoring CORDIC on the top 30 bits of the normalized pair.
   // ------------------------------------------------------------------
   tcch_pkg::cor_type cor_ff [1:CORDIC_STAGES];
   tcch_pkg::cor_type cor0;

   always_comb begin
      cor0.cx   = $signed({3'b000, norm_ff[6].ux[63:34]});
      cor0.cy   = $signed({3'b000, norm_ff[6].uy[63:34]});
      cor0.z    = 34'sd0;
      cor0.xneg = norm_ff[6].xneg;
      cor0.yneg = norm_ff[6].yneg;
      cor0.zero = norm_ff[6].zero;
      cor0.flat = norm_ff[6].flat;
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cor
      localparam logic signed [33:0] ATAN = $signed({2'b00, tcch_pkg::atan_tab(i)});
      tcch_pkg::cor_type src, nxt;
      if (i == 0) begin : g_first
         assign src = cor0;
      end else begin : g_rest
         assign src = cor_ff[i];
      end
      always_comb begin
         nxt = src;
         if (!src.cy[32]) begin
            nxt.cx = src.cx + (src.cy >>> i);
            nxt.cy = src.cy - (src.cx >>> i);
            nxt.z  = src.z + ATAN;
         end else begin
            nxt.cx = src.cx - (src.cy >>> i);
            nxt.cy = src.cy + (src.cx >>> i);
            nxt.z  = src.z - ATAN;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            cor_ff[i+1] <= nxt;
         end
      end
   end

   // ------------------------------------------------------------------
   // Clamp to the first quadrant and unfold by the signs of X and Y.
   // ------------------------------------------------------------------
   tcch_pkg::cor_type cor_last;
   logic [31:0] q, ang_in, ang_ff;
   logic        angflat_ff;

   assign cor_last = cor_ff[CORDIC_STAGES];

   always_comb begin
      if (cor_last.z < 34'sd0) begin
         q = 32'd0;
      end else if (cor_last.z > 34'sd1073741824) begin
         q = 32'h4000_0000;
      end else begin
         q = cor_last.z[31:0];
      end
      priority if (cor_last.zero) begin
         ang_in = 32'd0;
      end else if (!cor_last.xneg && !cor_last.yneg) begin
         ang_in = q;
      end else if (cor_last.xneg && !cor_last.yneg) begin
         ang_in = 32'h8000_0000 - q;
      end else if (cor_last.xneg) begin
         ang_in = 32'h8000_0000 + q;
      end else begin
         ang_in = 32'd0 - q;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff     <= ang_in;
         angflat_ff <= cor_last.flat;
      end
   end

   // Scale the angle to hundredths of a degree.
   logic [47:0] prod_ff;
   logic        prodflat_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff     <= 48'(ang_ff) * 48'(tcch_pkg::HEADING_WRAP);
         prodflat_ff <= angflat_ff;
      end
   end

   // Round, wrap a full turn to zero, and hold in the output register.
   logic [48:0] hsum;
   logic [16:0] hrnd;
   logic [15:0] heading_ff, heading_in;
   logic        free_fall_ff;

   always_comb begin
      hsum = 49'(prod_ff) + 49'h0_8000_0000;
      hrnd = hsum[48:32];
      heading_in = (hrnd >= 17'(tcch_pkg::HEADING_WRAP)) ? 16'd0 : hrnd[15:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         heading_ff   <= heading_in;
         free_fall_ff <= prodflat_ff;
      end
   end

   assign rsp_if.valid     = vld_ff[NST-1];
   assign rsp_if.heading   = heading_ff;
   assign rsp_if.free_fall = free_fall_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   `TCCH_ASSERT_IMP(a_heading_range, rsp_if.valid,
                    rsp_if.heading < 16'(tcch_pkg::HEADING_WRAP), "heading out of range")
   `TCCH_ASSERT_NXT(a_stall_freeze, !en, $stable(vld_ff), "pipeline moved while stalled")
   `TCCH_ASSERT_NXT(a_entry, req_if.valid && req_if.ready, vld_ff[0],
                    "accepted word did not enter the pipeline")

endmodule
